/* src/wpsa_pkg.sv */
package wpsa_pkg;

  localparam int SCORE_BITS = 24;
  localparam int COORD_W    = 32;
  localparam int POS_W      = COORD_W + 3;
  localparam int RIDX_W     = 12;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_POS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd5;

  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] start_pos;
    logic [COORD_W-1:0] stop_pos;
    logic [RIDX_W-1:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic                         saturated;
  } out_word_t;

  // commands to the score bank
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_READ,
    CMD_INC,
    CMD_DEC,
    CMD_ZERO
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic sat_hit;
  } bank_stat_t;

  typedef enum logic [1:0] {
    RNG_HEAD,
    RNG_TAIL,
    RNG_MID
  } rng_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FILTER,
    S_HEAD,
    S_TAIL,
    S_CLIP,
    S_RUN,
    S_DRAIN,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

endpackage

/* src/wpsa_bank.sv */
module wpsa_bank
  import wpsa_pkg::*;
#(
  parameter int DEPTH = 4096,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  input  logic [IDX_W-1:0]             addr,
  output logic signed [SCORE_BITS-1:0] rdata,
  output bank_stat_t                   stat
);

  logic signed [SCORE_BITS-1:0] mem [DEPTH];
  logic signed [SCORE_BITS-1:0] rdata_r;
  logic                         pend_r;
  logic                         pend_inc_r;
  logic [IDX_W-1:0]             pend_addr_r;

  logic                         at_limit;
  logic signed [SCORE_BITS-1:0] upd_val;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic signed [SCORE_BITS-1:0] wr_data;
  logic                         rd_en;

  // saturating step of one unit up or down
  always_comb begin
    at_limit = pend_inc_r ? (rdata_r == SCORE_MAX) : (rdata_r == SCORE_MIN);
    if (at_limit) begin
      upd_val = rdata_r;
    end else if (pend_inc_r) begin
      upd_val = rdata_r + SCORE_BITS'(1);
    end else begin
      upd_val = rdata_r - SCORE_BITS'(1);
    end
  end

  always_comb begin
    rd_en   = (cmd == CMD_READ) || (cmd == CMD_INC) || (cmd == CMD_DEC);
    wr_en   = pend_r || (cmd == CMD_ZERO);
    wr_addr = pend_r ? pend_addr_r : addr;
    wr_data = pend_r ? upd_val : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= (cmd == CMD_INC) || (cmd == CMD_DEC);
    end
  end

  always_ff @(posedge clk) begin
    pend_inc_r  <= (cmd == CMD_INC);
    pend_addr_r <= addr;
  end

  assign rdata        = rdata_r;
  assign stat.busy    = pend_r;
  assign stat.sat_hit = pend_r && at_limit;

endmodule

/* src/window_protection_score_accumulator.sv */
// Window protection score accumulator.
// Input channel in_valid/in_ready/in_data carries one command word: add an
// interval, read one score, or clear the store. Result channel
// out_valid/out_ready/out_data returns exactly one word per command: the
// score for a read (zero otherwise) and the saturation flag of an add.
// Configuration is written through cfg_we/cfg_index/cfg_wdata at any time,
// but only changes behavior safely while no command is in flight.
// One command is worked at a time; in_ready is high only when idle.
// Add: setup from the accepting cycle on (filter, window math, one clip
// step per window), a sweep over every store position covered by the
// head, tail and middle windows (one read-modify-write per cycle through
// the score bank port), then a drain of the pending bank write and the
// posting of the result. Read: a bank read, then the result. Clear: the
// whole store is zeroed, one entry per cycle. After reset the store is
// swept to zero with in_ready low; configuration writes are taken meanwhile.
// The result sits in an output register and the next word is taken while
// it waits. If the receiver stalls until the next result is ready, the
// block holds that result in its final state, with in_ready low, until
// the waiting word leaves.
module window_protection_score_accumulator
  import wpsa_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  // configuration registers
  logic [COORD_W-1:0] win_r;
  logic [COORD_W-1:0] first_r;
  logic [COORD_W-1:0] last_r;
  logic               filt_on_r;
  logic [COORD_W-1:0] min_len_r;
  logic [COORD_W-1:0] max_len_r;

  // sequencer and work registers
  state_t                       state_r, state_nxt;
  rng_t                         rng_r, rng_nxt;
  logic [CNT_W-1:0]             cur_r, cur_nxt;
  logic [CNT_W-1:0]             end_r, end_nxt;
  logic                         clr_op_r, clr_op_nxt;
  logic [1:0]                   op_r, op_nxt;
  pos_t                         s_r, s_nxt;
  pos_t                         e_r, e_nxt;
  logic [RIDX_W-1:0]            ridx_r, ridx_nxt;
  pos_t                         head_lo_r, head_lo_nxt;
  pos_t                         head_hi_r, head_hi_nxt;
  pos_t                         tail_lo_r, tail_lo_nxt;
  pos_t                         tail_hi_r, tail_hi_nxt;
  logic signed [SCORE_BITS-1:0] score_r, score_nxt;
  logic                         sat_r, sat_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_word_t                    out_data_r, out_data_nxt;

  // bank interface
  cmd_t                         bank_cmd;
  logic [IDX_W-1:0]             bank_addr;
  logic signed [SCORE_BITS-1:0] bank_rdata;
  bank_stat_t                   bank_stat;

  // combinational datapath
  logic             accept;
  logic             load_out;
  pos_t             h;
  pos_t             first_p;
  pos_t             last_p;
  pos_t             min_p;
  pos_t             max_p;
  pos_t             depth_p;
  pos_t             len;
  logic             filt_ok;
  pos_t             sum_lo;
  pos_t             sum_hi;
  pos_t             sel_lo;
  pos_t             sel_hi;
  pos_t             lo_rel;
  pos_t             hi_rel;
  pos_t             lo_c;
  pos_t             hi_c;
  logic             run_ok;
  logic [CNT_W-1:0] cur_inc;
  logic             run_last;
  logic             clr_last;
  logic             rd_hit;

  //--------------------------------------------------------------------------
  // Configuration port: plain writes, no read-back
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      first_r   <= '0;
      last_r    <= COORD_W'(4095);
      filt_on_r <= 1'b0;
      min_len_r <= '0;
      max_len_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_WIDTH: win_r     <= cfg_wdata;
        CFG_FIRST_POS:    first_r   <= cfg_wdata;
        CFG_LAST_POS:     last_r    <= cfg_wdata;
        CFG_FILTER_ON:    filt_on_r <= cfg_wdata[0];
        CFG_MIN_LENGTH:   min_len_r <= cfg_wdata;
        CFG_MAX_LENGTH:   max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Window arithmetic. Coordinates are widened to signed so that start - h
  // can go below zero and stop + h can pass 2^32 without wrapping.
  //--------------------------------------------------------------------------
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    h       = {4'b0, win_r[COORD_W-1:1]};
    first_p = {3'b0, first_r};
    last_p  = {3'b0, last_r};
    min_p   = {3'b0, min_len_r};
    max_p   = {3'b0, max_len_r};
    depth_p = POS_W'(STORE_DEPTH);

    // an inverted interval gives a negative length and fails the lower bound
    len     = e_r - s_r;
    filt_ok = !filt_on_r || ((len >= min_p) && (len < max_p));

    // head window in S_HEAD, tail window in S_TAIL
    if (state_r == S_TAIL) begin
      sum_lo = e_r - h;
      sum_hi = e_r + h;
    end else begin
      sum_lo = s_r - h;
      sum_hi = s_r + h;
    end

    // pick the range being worked: the middle lies between head and tail
    case (rng_r)
      RNG_HEAD: begin
        sel_lo = head_lo_r;
        sel_hi = head_hi_r;
      end
      RNG_TAIL: begin
        sel_lo = tail_lo_r;
        sel_hi = tail_hi_r;
      end
      default: begin
        sel_lo = head_hi_r;
        sel_hi = tail_lo_r;
      end
    endcase

    // clip to the store and turn into store indexes
    lo_rel = sel_lo - first_p;
    hi_rel = sel_hi - first_p;
    lo_c   = (lo_rel < 0) ? '0 : lo_rel;
    hi_c   = (hi_rel > depth_p) ? depth_p : hi_rel;
    run_ok = lo_c < hi_c;

    cur_inc  = cur_r + CNT_W'(1);
    run_last = (cur_inc == end_r);
    clr_last = (cur_r == CNT_W'(STORE_DEPTH - 1));
    rd_hit   = 32'(ridx_r) < 32'(STORE_DEPTH);
  end

  //--------------------------------------------------------------------------
  // Sequencer: next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_op_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_ADD:   state_nxt = S_FILTER;
            OP_READ:  state_nxt = S_READ;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_FILTER: state_nxt = filt_ok ? S_HEAD : S_DONE;
      S_HEAD:   state_nxt = S_TAIL;
      S_TAIL:   state_nxt = S_CLIP;
      S_CLIP: begin
        if (run_ok) begin
          state_nxt = S_RUN;
        end else if (rng_r == RNG_MID) begin
          state_nxt = S_DRAIN;
        end
      end
      S_RUN: begin
        if (run_last) begin
          state_nxt = (rng_r == RNG_MID) ? S_DRAIN : S_CLIP;
        end
      end
      S_DRAIN: begin
        if (!bank_stat.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_READ:  state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer: outputs to the channel and the score bank
  //--------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    bank_cmd  = CMD_NOP;
    bank_addr = cur_r[IDX_W-1:0];
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_CLEAR: bank_cmd = CMD_ZERO;
      S_RUN:   bank_cmd = (rng_r == RNG_MID) ? CMD_INC : CMD_DEC;
      S_READ: begin
        bank_addr = IDX_W'(ridx_r);
        bank_cmd  = rd_hit ? CMD_READ : CMD_NOP;
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // Work registers: next values
  //--------------------------------------------------------------------------
  always_comb begin
    rng_nxt     = rng_r;
    cur_nxt     = cur_r;
    end_nxt     = end_r;
    clr_op_nxt  = clr_op_r;
    op_nxt      = op_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    ridx_nxt    = ridx_r;
    head_lo_nxt = head_lo_r;
    head_hi_nxt = head_hi_r;
    tail_lo_nxt = tail_lo_r;
    tail_hi_nxt = tail_hi_r;
    score_nxt   = score_r;
    // collect clamp hits from the bank write stage as they retire
    sat_nxt     = sat_r || bank_stat.sat_hit;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.opcode;
          s_nxt      = {3'b0, in_data.start_pos};
          e_nxt      = {3'b0, in_data.stop_pos};
          ridx_nxt   = in_data.read_index;
          score_nxt  = '0;
          sat_nxt    = 1'b0;
          cur_nxt    = '0;
          clr_op_nxt = (in_data.opcode == OP_CLEAR);
        end
      end
      S_CLEAR: begin
        cur_nxt = clr_last ? '0 : cur_inc;
      end
      S_HEAD: begin
        head_lo_nxt = (sum_lo < first_p) ? first_p : sum_lo;
        head_hi_nxt = (sum_hi > e_r) ? e_r : sum_hi;
      end
      S_TAIL: begin
        tail_lo_nxt = (sum_lo < head_hi_r) ? head_hi_r : sum_lo;
        tail_hi_nxt = (sum_hi > last_p) ? last_p : sum_hi;
        rng_nxt     = RNG_HEAD;
      end
      S_CLIP: begin
        if (run_ok) begin
          cur_nxt = lo_c[CNT_W-1:0];
          end_nxt = hi_c[CNT_W-1:0];
        end else if (rng_r == RNG_HEAD) begin
          rng_nxt = RNG_TAIL;
        end else begin
          rng_nxt = RNG_MID;
        end
      end
      S_RUN: begin
        cur_nxt = cur_inc;
        if (run_last && (rng_r != RNG_MID)) begin
          rng_nxt = (rng_r == RNG_HEAD) ? RNG_TAIL : RNG_MID;
        end
      end
      S_RWAIT: begin
        score_nxt = rd_hit ? bank_rdata : '0;
      end
      default: ;
    endcase
  end

  // result register: hold the word while the receiver stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.score     = score_r;
      out_data_nxt.saturated = sat_r;
    end
  end

  //--------------------------------------------------------------------------
  // Registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      clr_op_r    <= 1'b0;
      rng_r       <= RNG_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      clr_op_r    <= clr_op_nxt;
      rng_r       <= rng_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    op_r       <= op_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    ridx_r     <= ridx_nxt;
    head_lo_r  <= head_lo_nxt;
    head_hi_r  <= head_hi_nxt;
    tail_lo_r  <= tail_lo_nxt;
    tail_hi_r  <= tail_hi_nxt;
    score_r    <= score_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  //--------------------------------------------------------------------------
  // Score bank: the store plus its saturating read-modify-write stage
  //--------------------------------------------------------------------------
  wpsa_bank #(
    .DEPTH (STORE_DEPTH)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (bank_cmd),
    .addr  (bank_addr),
    .rdata (bank_rdata),
    .stat  (bank_stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // no update may still be in flight once a new word can enter
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !bank_stat.busy)
    else $error("bank write pending while ready for a new word");

  // clamp hits only come from the add sweep
  a_sat_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    bank_stat.sat_hit |-> (state_r == S_RUN || state_r == S_CLIP || state_r == S_DRAIN))
    else $error("saturation reported outside an add sweep");

  // the sweep pointer stays inside the range being worked
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cur_r < end_r))
    else $error("sweep pointer ran past the range end");
`endif

endmodule
